// File: rtl/core/dwdb_pkg.sv
`timescale 1ns / 1ps

package dwdb_pkg;

  // point memory geometry
  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned LenW      = AddrW + 1;

  // field and accumulator widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CntW    = 16;
  localparam int unsigned SumW    = SampleW + CntW;
  localparam int unsigned QuoW    = SampleW + 1;
  localparam int unsigned StepW   = $clog2(QuoW);
  localparam int unsigned SizeW   = 16;
  localparam int unsigned WidthW  = 13;

  // register file
  localparam int unsigned DataW  = 32;
  localparam int unsigned PaddrW = 4;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t RegSampleCount = 2'd0;
  localparam reg_idx_t RegPixelWidth  = 2'd1;
  localparam reg_idx_t RegScrollMode  = 2'd2;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/dwdb_div.sv
`timescale 1ns / 1ps

module dwdb_div import dwdb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [QuoW-1:0]    NegLim = QuoW'(1) << (SampleW - 1);
  localparam logic [QuoW-1:0]    PosLim = NegLim - QuoW'(1);
  localparam logic [SampleW-1:0] SatMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic [SampleW-1:0] SatMax = {1'b0, {(SampleW-1){1'b1}}};

  logic               busy_q;
  logic               done_q;
  logic               neg_q;
  logic [StepW-1:0]   step_q;
  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    div_q;
  logic [QuoW-1:0]    quo_q;
  logic [SampleW-1:0] res_q;

  logic [SumW-1:0]    mag;
  logic [CntW:0]      trial;
  logic [CntW:0]      diff;
  logic               ge;
  logic [CntW-1:0]    rem_n;
  logic [QuoW-1:0]    quo_n;
  logic [QuoW-1:0]    quo_neg;
  logic [SampleW-1:0] sat;
  logic               last_step;

  // magnitude of the signed dividend
  assign mag = req_i.dividend[SumW-1] ? (~req_i.dividend + SumW'(1)) : req_i.dividend;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_n = ge ? diff[CntW-1:0] : trial[CntW-1:0];
  assign quo_n = {quo_q[QuoW-2:0], ge};

  assign last_step = step_q == StepW'(QuoW - 1);

  // sign and clamp to the sample range
  assign quo_neg = ~quo_n + QuoW'(1);
  always_comb begin
    if (neg_q) begin
      sat = (quo_n > NegLim) ? SatMin : quo_neg[SampleW-1:0];
    end else begin
      sat = (quo_n > PosLim) ? SatMax : quo_n[SampleW-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath; the quotient fits QuoW bits as the average stays in range,
  // so the top dividend bits seed the partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[SumW-1];
      div_q <= req_i.divisor;
      rem_q <= {1'b0, mag[SumW-1:QuoW]};
      quo_q <= mag[QuoW-1:0];
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (last_step) begin
        res_q <= sat;
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

// File: rtl/core/decimating_waveform_display_buffer_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        input      in_valid_i/in_ready_o   req_type_i, sample_i, read_index_i
// out       output     out_valid_o/out_ready_i is_read_reply_o, point_index_o, point_value_o
// config    input      psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// after reset a clearing pass zeroes every entry of the point memory; no request
// is taken meanwhile, register writes are.
// a read request passes StRd, a direct sample StStore, an averaging sample that closes
// no point StMul and StCmp; one that closes a point also StDiv (17-step divider), StStore.
// one request is in flight at a time; a result waits in the output register, and
// a stalled output holds the block only when a second result is ready.

module decimating_waveform_display_buffer_top import dwdb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [AddrW-1:0]          read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_read_reply_o,
  output logic [AddrW-1:0]          point_index_o,
  output logic signed [SampleW-1:0] point_value_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  localparam int unsigned ProdW = CntW + SizeW;

  localparam logic [2:0] StClr   = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StStore = 3'd5;
  localparam logic [2:0] StRd    = 3'd6;

  logic [2:0]         state_q, state_d;

  logic [SizeW-1:0]   sample_count_q;
  logic [WidthW-1:0]  pixel_width_q;
  logic               scroll_mode_q;

  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    sip_q;
  logic [CntW-1:0]    added_q;
  logic [AddrW-1:0]   front_q;
  logic [AddrW-1:0]   ring_q;
  logic [AddrW-1:0]   clr_cnt_q;

  logic [SampleW-1:0] sample_q;
  logic [AddrW-1:0]   rd_idx_q;
  logic               rd_in_range_q;
  logic [SampleW-1:0] rd_data_q;
  logic [ProdW-1:0]   prod_a_q;
  logic [ProdW-1:0]   prod_b_q;

  logic               out_valid_q;
  logic               is_read_q;
  logic [AddrW-1:0]   pidx_q;
  logic [SampleW-1:0] pval_q;

  logic [SampleW-1:0] disp_mem [MaxPoints];

  logic [SizeW-1:0]   eff_size;
  logic [WidthW-1:0]  eff_width;
  logic [LenW-1:0]    trace_len;
  logic               avg_mode;
  logic [AddrW-1:0]   rb;
  logic [AddrW-1:0]   front_eff;
  logic [LenW-1:0]    front_inc;
  logic               front_wrap;
  logic [AddrW-1:0]   front_next;
  logic [LenW-1:0]    ring_inc;
  logic [AddrW-1:0]   ring_next;
  logic [LenW-1:0]    len_m1;

  logic               in_acc;
  logic               slot_free;
  logic               point_lt;
  logic               load_store;
  logic               load_rd;
  logic [SampleW-1:0] store_val;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [SampleW-1:0] mem_wdata;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;

  logic               cfg_we;
  reg_idx_t           cfg_idx;
  logic               clear_prog;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // memory address of a display position, rotated by the ring base
  function automatic logic [AddrW-1:0] phys_addr(input logic [AddrW-1:0] base,
                                                 input logic [AddrW-1:0] pos,
                                                 input logic [LenW-1:0]  len);
    logic [LenW-1:0] a;
    a = LenW'(base) + LenW'(pos);
    if (a >= len) begin
      a = a - len;
    end
    return a[AddrW-1:0];
  endfunction

  // effective geometry
  assign eff_size = (sample_count_q == '0) ? SizeW'(1) : sample_count_q;
  always_comb begin
    if (pixel_width_q == '0) begin
      eff_width = WidthW'(1);
    end else if (pixel_width_q > WidthW'(MaxPoints)) begin
      eff_width = WidthW'(MaxPoints);
    end else begin
      eff_width = pixel_width_q;
    end
  end
  assign avg_mode  = eff_size > SizeW'(eff_width);
  assign trace_len = avg_mode ? LenW'(eff_width) : LenW'(eff_size);
  assign len_m1    = trace_len - LenW'(1);

  // pointer arithmetic
  assign rb         = (LenW'(ring_q) < trace_len) ? ring_q : '0;
  assign front_eff  = (LenW'(front_q) >= trace_len) ? '0 : front_q;
  assign front_inc  = LenW'(front_eff) + LenW'(1);
  assign front_wrap = front_inc >= trace_len;
  assign front_next = front_wrap ? '0 : front_inc[AddrW-1:0];
  assign ring_inc   = LenW'(rb) + LenW'(1);
  assign ring_next  = (ring_inc >= trace_len) ? '0 : ring_inc[AddrW-1:0];

  // handshakes
  assign in_ready_o = state_q == StIdle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign point_lt   = prod_a_q < prod_b_q;
  assign load_store = (state_q == StStore) && slot_free;
  assign load_rd    = (state_q == StRd) && slot_free;
  assign store_val  = avg_mode ? div_rsp.quotient : sample_q;

  // register port
  assign pready     = 1'b1;
  assign cfg_idx    = paddr[3:2];
  assign cfg_we     = psel && penable && pwrite && pready;
  assign clear_prog = cfg_we && ((cfg_idx == RegSampleCount) || (cfg_idx == RegPixelWidth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SizeW'(1);
      pixel_width_q  <= WidthW'(1);
      scroll_mode_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegSampleCount: sample_count_q <= pwdata[SizeW-1:0];
        RegPixelWidth:  pixel_width_q  <= pwdata[WidthW-1:0];
        RegScrollMode:  scroll_mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegSampleCount: prdata = DataW'(sample_count_q);
      RegPixelWidth:  prdata = DataW'(pixel_width_q);
      RegScrollMode:  prdata = DataW'(scroll_mode_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClr: begin
        if (clr_cnt_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc) begin
          if (req_type_i) state_d = StRd;
          else if (avg_mode) state_d = StMul;
          else state_d = StStore;
        end
      end
      StMul: state_d = StCmp;
      StCmp: state_d = point_lt ? StIdle : StDiv;
      StDiv: begin
        if (div_rsp.done) state_d = StStore;
      end
      StStore: begin
        if (slot_free) state_d = StIdle;
      end
      StRd: begin
        if (slot_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClr;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClr) clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // accumulation and pointer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sip_q   <= '0;
      added_q <= '0;
      front_q <= '0;
      ring_q  <= '0;
    end else if (clear_prog) begin
      sum_q   <= '0;
      sip_q   <= '0;
      added_q <= '0;
      front_q <= '0;
      ring_q  <= '0;
    end else if (in_acc && !req_type_i && avg_mode) begin
      sum_q   <= sum_q + {{(SumW-SampleW){sample_i[SampleW-1]}}, sample_i};
      sip_q   <= (sip_q == '1) ? sip_q : sip_q + CntW'(1);
      added_q <= (added_q == '1) ? added_q : added_q + CntW'(1);
      front_q <= front_eff;
    end else if (load_store) begin
      if (avg_mode) begin
        sum_q   <= '0;
        sip_q   <= '0;
        front_q <= front_next;
        if (front_wrap) added_q <= '0;
      end else if (!scroll_mode_q) begin
        front_q <= front_next;
      end
      if (scroll_mode_q) ring_q <= ring_next;
    end
  end

  // request payload and close test products
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q      <= sample_i;
      rd_idx_q      <= read_index_i;
      rd_in_range_q <= LenW'(read_index_i) < trace_len;
    end
    if (state_q == StMul) begin
      prod_a_q <= ProdW'(added_q) * ProdW'(eff_width);
      prod_b_q <= ProdW'(front_q) * ProdW'(eff_size);
    end
  end

  // divider for the point average
  assign div_req.start    = (state_q == StCmp) && !point_lt;
  assign div_req.dividend = sum_q;
  assign div_req.divisor  = sip_q;

  dwdb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // point memory: one write port, one registered read port
  assign mem_we    = (state_q == StClr) || load_store;
  assign mem_waddr = (state_q == StClr) ? clr_cnt_q
                   : phys_addr(rb, scroll_mode_q ? '0 : front_eff, trace_len);
  assign mem_wdata = (state_q == StClr) ? '0 : store_val;
  assign mem_re    = in_acc && req_type_i;
  assign mem_raddr = phys_addr(rb, read_index_i, trace_len);

  always_ff @(posedge clk_i) begin
    if (mem_we) disp_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= disp_mem[mem_raddr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_store || load_rd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_store) begin
      is_read_q <= 1'b0;
      pidx_q    <= scroll_mode_q ? len_m1[AddrW-1:0] : front_eff;
      pval_q    <= store_val;
    end else if (load_rd) begin
      is_read_q <= 1'b1;
      pidx_q    <= rd_idx_q;
      pval_q    <= rd_in_range_q ? rd_data_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_read_reply_o = is_read_q;
  assign point_index_o   = pidx_q;
  assign point_value_o   = pval_q;

  // checks
  a_ring_in_trace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(ring_q) < trace_len)
    else $error("ring base outside the trace");

  a_front_in_trace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (LenW'(front_q) < trace_len))
    else $error("front pointer outside the trace");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == StStore) || (state_q == StRd)))
    else $error("result raised outside store or read");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDiv))
    else $error("divider finished while not awaited");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> !mem_we)
    else $error("memory written during a read request");

endmodule

// File: verif/decimating_waveform_display_buffer_top_tb.sv
`timescale 1ns / 1ps

module decimating_waveform_display_buffer_top_tb;
  import dwdb_pkg::*;

  localparam int unsigned ItemTarget   = 1750;
  localparam int unsigned TailItems    = 150;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 20000;

  typedef enum logic {REQ_SAMPLE = 1'b0, REQ_READ = 1'b1} req_kind_e;
  typedef enum logic {REPLY_POINT = 1'b0, REPLY_READ = 1'b1} reply_kind_e;
  typedef enum logic {ROW_REG_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct {
    reply_kind_e               kind;
    logic [AddrW-1:0]          index;
    logic signed [SampleW-1:0] value;
  } reply_t;

  typedef struct {
    row_kind_e                 kind;
    reg_idx_t                  reg_sel;
    logic [DataW-1:0]          reg_val;
    req_kind_e                 req;
    logic signed [SampleW-1:0] smp;
    logic [AddrW-1:0]          ridx;
    bit                        typed_in;
    reply_t                    want;
  } dir_row_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic                      req_type_i   = 1'b0;
  logic signed [SampleW-1:0] sample_i     = '0;
  logic [AddrW-1:0]          read_index_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic                      is_read_reply_o;
  logic [AddrW-1:0]          point_index_o;
  logic signed [SampleW-1:0] point_value_o;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [PaddrW-1:0]         paddr        = '0;
  logic [DataW-1:0]          pwdata       = '0;
  logic [DataW-1:0]          prdata;
  logic                      pready;

  decimating_waveform_display_buffer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .sample_i       (sample_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_read_reply_o(is_read_reply_o),
    .point_index_o  (point_index_o),
    .point_value_o  (point_value_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the trace state and registers
  logic signed [SampleW-1:0] point_mem [MaxPoints];
  logic [SizeW-1:0]          cfg_size   = 16'd1;
  logic [WidthW-1:0]         cfg_width  = 13'd1;
  logic                      cfg_scroll = 1'b0;
  longint                    acc_sum     = 0;
  int unsigned               acc_count   = 0;
  int unsigned               added_count = 0;
  int unsigned               front_pos   = 0;
  int unsigned               ring_ptr    = 0;

  reply_t   expected_replies [$];
  dir_row_t dir_rows [$];
  reply_t   blank_reply;

  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned points_seen    = 0;
  int unsigned reads_seen     = 0;
  int unsigned reg_writes     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  bit          hold_req       = 1'b0;
  bit          steady_tail    = 1'b0;
  bit          rx_calm        = 1'b0;
  bit          tx_calm        = 1'b0;

  initial begin
    foreach (point_mem[i]) point_mem[i] = '0;
  end

  function automatic int unsigned size_eff();
    return (cfg_size == '0) ? 32'd1 : 32'(cfg_size);
  endfunction

  function automatic int unsigned width_eff();
    int unsigned w;
    w = (cfg_width == '0) ? 32'd1 : 32'(cfg_width);
    return (w > MaxPoints) ? MaxPoints : w;
  endfunction

  function automatic int unsigned trace_len();
    return (size_eff() < width_eff()) ? size_eff() : width_eff();
  endfunction

  // display position to memory slot through the rotating base
  function automatic int unsigned mem_addr(int unsigned pos, int unsigned len);
    int unsigned a;
    a = ((ring_ptr < len) ? ring_ptr : 0) + pos;
    if (a >= len) a -= len;
    return (a < MaxPoints) ? a : 0;
  endfunction

  function automatic void clear_progress();
    front_pos   = 0;
    ring_ptr    = 0;
    acc_sum     = 0;
    acc_count   = 0;
    added_count = 0;
  endfunction

  // write a finished point, give back its display position
  function automatic int unsigned store_point(logic signed [SampleW-1:0] v, int unsigned len);
    int unsigned b;
    if (cfg_scroll) begin
      b = (ring_ptr < len) ? ring_ptr : 0;
      point_mem[b] = v;
      b++;
      if (b >= len) b = 0;
      ring_ptr = b;
      return len - 1;
    end
    if (front_pos >= len) front_pos = 0;
    point_mem[mem_addr(front_pos, len)] = v;
    return front_pos;
  endfunction

  // advance the trace by one request, 1 when a reply is due
  function automatic bit trace_step(input req_kind_e req, input logic signed [SampleW-1:0] smp,
                                    input logic [AddrW-1:0] ridx, output reply_t r);
    int unsigned len;
    int unsigned size;
    int unsigned width;
    int unsigned pos;
    longint      avg;
    len   = trace_len();
    size  = size_eff();
    width = width_eff();
    if (req == REQ_READ) begin
      r.kind  = REPLY_READ;
      r.index = ridx;
      r.value = (32'(ridx) < len) ? point_mem[mem_addr(32'(ridx), len)] : '0;
      return 1'b1;
    end
    r.kind = REPLY_POINT;
    // averaging: close a point once enough samples have gone in
    if (size > width) begin
      acc_sum += longint'(smp);
      acc_count++;
      added_count++;
      if (front_pos >= len) front_pos = 0;
      if (longint'(added_count) * longint'(width) < longint'(front_pos) * longint'(size))
        return 1'b0;
      avg = acc_sum / longint'(acc_count);
      if (avg < -32768) avg = -32768;
      if (avg > 32767) avg = 32767;
      pos = store_point(avg[SampleW-1:0], len);
      front_pos++;
      if (front_pos >= len) begin
        front_pos   = 0;
        added_count = 0;
      end
      acc_sum   = 0;
      acc_count = 0;
      r.index   = pos[AddrW-1:0];
      r.value   = avg[SampleW-1:0];
      return 1'b1;
    end
    // direct: every sample is a point
    pos = store_point(smp, len);
    if (!cfg_scroll) begin
      front_pos++;
      if (front_pos >= len) front_pos = 0;
    end
    r.index = pos[AddrW-1:0];
    r.value = smp;
    return 1'b1;
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom());
    endcase
  endfunction

  // directed table
  function automatic void add_reg_row(reg_idx_t idx, logic [DataW-1:0] val);
    dir_row_t row;
    row.kind     = ROW_REG_WRITE;
    row.reg_sel  = idx;
    row.reg_val  = val;
    row.req      = REQ_SAMPLE;
    row.smp      = '0;
    row.ridx     = '0;
    row.typed_in = 1'b0;
    row.want     = blank_reply;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_req_row(req_kind_e req, logic signed [SampleW-1:0] smp,
                                      logic [AddrW-1:0] ridx);
    dir_row_t row;
    row.kind     = ROW_REQUEST;
    row.reg_sel  = RegSampleCount;
    row.reg_val  = '0;
    row.req      = req;
    row.smp      = smp;
    row.ridx     = ridx;
    row.typed_in = 1'b0;
    row.want     = blank_reply;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(req_kind_e req, logic signed [SampleW-1:0] smp,
                                          logic [AddrW-1:0] ridx, reply_kind_e kind,
                                          logic [AddrW-1:0] index,
                                          logic signed [SampleW-1:0] value);
    add_req_row(req, smp, ridx);
    dir_rows[$].typed_in   = 1'b1;
    dir_rows[$].want.kind  = kind;
    dir_rows[$].want.index = index;
    dir_rows[$].want.value = value;
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input req_kind_e req, input logic signed [SampleW-1:0] smp,
                              input logic [AddrW-1:0] ridx, input bit use_fixed,
                              input reply_t fixed);
    reply_t r;
    bit     has_reply;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    sample_i     <= smp;
    read_index_i <= ridx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    has_reply = trace_step(req, smp, ridx, r);
    if (use_fixed) expected_replies.push_back(fixed);
    else if (has_reply) expected_replies.push_back(r);
    requests_sent++;
  endtask

  task automatic idle_for(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // drain all replies and let an unfinished sample run out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk_i);
    reg_writes++;
    case (idx)
      RegSampleCount: begin
        cfg_size = val[SizeW-1:0];
        clear_progress();
      end
      RegPixelWidth: begin
        cfg_width = val[WidthW-1:0];
        clear_progress();
      end
      RegScrollMode: cfg_scroll = val[0];
      default: ;
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    if (expected_replies.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: unexpected result kind %0d index %0d value %0d",
                 is_read_reply_o, point_index_o, point_value_o);
      return;
    end
    want = expected_replies.pop_front();
    if (want.kind !== is_read_reply_o || want.index !== point_index_o ||
        want.value !== point_value_o) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected kind %0d index %0d value %0d, got kind %0d index %0d value %0d",
                 want.kind, want.index, want.value,
                 is_read_reply_o, point_index_o, point_value_o);
    end
    if (is_read_reply_o) reads_seen++;
    else points_seen++;
  endtask

  // result side: check, then pick ready for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) check_reply();
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (!steady_tail && !rx_calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      phase;
    int unsigned      kind;
    int unsigned      s;
    int unsigned      w;
    int unsigned      n_items;
    int unsigned      len;
    logic [DataW-1:0] mode;
    req_kind_e        req;
    logic [AddrW-1:0] ridx;

    blank_reply.kind  = REPLY_POINT;
    blank_reply.index = '0;
    blank_reply.value = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-point trace straight after reset
    add_checked_row(REQ_READ, 16'sd0, 12'd0, REPLY_READ, 12'd0, 16'sd0);
    add_checked_row(REQ_READ, 16'sh1234, 12'd4095, REPLY_READ, 12'd4095, 16'sd0);
    add_checked_row(REQ_SAMPLE, 16'sh7FFF, 12'd0, REPLY_POINT, 12'd0, 16'sh7FFF);
    add_checked_row(REQ_READ, 16'sd0, 12'd0, REPLY_READ, 12'd0, 16'sh7FFF);
    add_checked_row(REQ_SAMPLE, 16'sh8000, 12'hFFF, REPLY_POINT, 12'd0, 16'sh8000);
    // zero geometry counts as one
    add_reg_row(RegSampleCount, 32'd0);
    add_reg_row(RegPixelWidth, 32'd0);
    add_checked_row(REQ_SAMPLE, 16'sd1, 12'd0, REPLY_POINT, 12'd0, 16'sd1);
    // averaging over two points, one with no result and a truncated mean
    add_reg_row(RegSampleCount, 32'd6);
    add_reg_row(RegPixelWidth, 32'd2);
    add_req_row(REQ_SAMPLE, 16'sd100, 12'd0);
    add_req_row(REQ_SAMPLE, -16'sd3, 12'd0);
    add_req_row(REQ_SAMPLE, -16'sd4, 12'd0);
    add_req_row(REQ_READ, 16'sd0, 12'd1);
    // scrolling appends at the right end
    add_reg_row(RegScrollMode, 32'd1);
    add_checked_row(REQ_SAMPLE, 16'sd7, 12'd0, REPLY_POINT, 12'd1, 16'sd7);
    add_req_row(REQ_READ, 16'sd0, 12'd0);
    // oversized width saturates, upper bits ignored
    add_reg_row(RegPixelWidth, 32'hFFFF_FFFF);
    add_checked_row(REQ_SAMPLE, -16'sd1, 12'd0, REPLY_POINT, 12'd5, -16'sd1);
    add_checked_row(REQ_READ, 16'sd0, 12'd5, REPLY_READ, 12'd5, -16'sd1);
    add_checked_row(REQ_READ, 16'sd0, 12'd6, REPLY_READ, 12'd6, 16'sd0);
    add_reg_row(RegScrollMode, 32'd0);
    add_req_row(REQ_SAMPLE, 16'sh5555, 12'hAAA);
    add_req_row(REQ_READ, 16'shAAAA, 12'd2);
    add_checked_row(REQ_READ, 16'sd0, 12'd4095, REPLY_READ, 12'd4095, 16'sd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG_WRITE) begin
        settle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].ridx,
                     dir_rows[i].typed_in, dir_rows[i].want);
      end
    end

    // random settings, each with a run of random requests
    phase = 0;
    while (requests_sent < ItemTarget) begin
      settle();
      kind = (phase == 0) ? 0 : (phase == 1) ? 5 : $urandom_range(0, 5);
      case (kind)
        0: begin
          w = $urandom_range(1, 6);
          s = w + $urandom_range(1, 5 * w + 4);
        end
        1: begin
          w = $urandom_range(2, 40);
          s = w * $urandom_range(2, 4) + $urandom_range(0, w);
        end
        2: begin
          s = $urandom_range(1, 10);
          w = s + $urandom_range(0, 50);
        end
        3: begin
          s = $urandom_range(1, 12);
          w = s;
        end
        4: begin
          s = $urandom_range(1, 65535);
          w = $urandom_range(1, 4096);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: begin s = 65535; w = 4096; end
            1: begin s = 0;     w = 0;    end
            2: begin s = 65535; w = 8191; end
            default: begin s = 1; w = 4096; end
          endcase
        end
      endcase
      write_reg(RegSampleCount, ($urandom() & 32'hFFFF_0000) | s);
      write_reg(RegPixelWidth, ($urandom() & 32'hFFFF_E000) | w);
      write_reg(RegScrollMode, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));

      n_items = $urandom_range(100, 190);
      for (int k = 0; k < n_items && requests_sent < ItemTarget; k++) begin
        if (k == n_items / 2) begin
          // output held off while the input keeps offering reads
          if (phase == 1 || $urandom_range(0, 4) == 0) begin
            hold_req = 1'b1;
            repeat (24) send_request(REQ_READ, rand_sample(), 12'($urandom_range(0, 7)),
                                     1'b0, blank_reply);
          end
          // mode flip alone keeps the trace progress
          if ($urandom_range(0, 2) == 0) begin
            settle();
            mode = {31'd0, ~cfg_scroll};
            write_reg(RegScrollMode, mode);
          end
        end
        if (requests_sent >= ItemTarget - TailItems) steady_tail = 1'b1;
        if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
        if (!steady_tail && !tx_calm && $urandom_range(0, 5) == 0)
          idle_for($urandom_range(1, 16));

        len = trace_len();
        ridx = 12'($urandom());
        if ($urandom_range(0, 3) == 0) begin
          req = REQ_READ;
          if ($urandom_range(0, 3) != 0)
            ridx = 12'($urandom_range(0, (len > 4095) ? 4095 : len));
        end else begin
          req = REQ_SAMPLE;
        end
        send_request(req, rand_sample(), ridx, 1'b0, blank_reply);
      end
      phase++;
    end

    // drain and watch for stray results
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d points and %0d read replies checked",
             requests_sent, points_seen, reads_seen);
    $display("over %0d register writes and %0d random geometries, %0d mismatches",
             reg_writes, phase, mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
